[hw/rtl/tqp_pkg.sv]
package tqp_pkg;

    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int DIVOUT_W  = 16;
    localparam int QCNT_W    = 3;

    localparam int DVD_W     = 21;
    localparam int DVS_W     = 16;

    localparam logic [DVD_W-1:0]  PIT_CLOCK = 21'd1193180;
    localparam logic [FREQ_W-1:0] FREQ_MIN  = 16'd20;
    localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'd20000;

    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_LOAD,
        S_DIVF,
        S_RESP
    } t_state;

endpackage

[hw/rtl/tqp_divider.sv]
module tqp_divider
    import tqp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one restoring step per cycle, MSB first
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/tqp_queue.sv]
module tqp_queue
    import tqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [FREQ_W-1:0]                  i_freq,
    input  logic [DUR_W-1:0]                   i_dur,
    input  logic                               i_pop,
    output logic [FREQ_W-1:0]                  o_freq,
    output logic [DUR_W-1:0]                   o_dur,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [FREQ_W-1:0] r_freq_mem [QUEUE_DEPTH];
    logic [DUR_W-1:0]  r_dur_mem  [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic [FREQ_W-1:0] r_rd_freq;
    logic [DUR_W-1:0]  r_rd_dur;

    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_inc;

    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            tail = PTR_W'(tail_sum);
        end
        if (r_head == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop) begin
                r_count <= r_count - 1'b1;
                r_head  <= head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_freq_mem[tail] <= i_freq;
            r_dur_mem[tail]  <= i_dur;
        end
        if (i_pop) begin
            r_rd_freq <= r_freq_mem[r_head];
            r_rd_dur  <= r_dur_mem[r_head];
        end
    end

    assign o_freq  = r_rd_freq;
    assign o_dur   = r_rd_dur;
    assign o_count = r_count;

endmodule

[hw/rtl/tone_queue_player.sv]
// Tone queue player.
// Input channel (i_valid / o_ready): one request per item. i_kind selects a
// tone request (frequency in Hz, length in ms) or one elapsed timer tick.
// Output channel (o_valid / i_ready): exactly one result per request, giving
// whether a tone request was queued, the speaker enable, the timer divisor
// of the sounding tone (0 while silent) and the number of waiting tones.
// One request is handled at a time; o_ready is low from acceptance until the
// result is taken. A request that starts no tone has its result valid in the
// cycle after acceptance. One that starts a tone pops the queue head (states
// S_POP, S_LOAD), then runs the radix-2 divider for the timer divisor,
// 21 steps, before its result is valid. The tick count comes from a
// constant reciprocal multiply in the same pass. The divider sets the pace.
// When the receiver holds i_ready low the result stays on the outputs and no
// new request is taken. Reset empties the queue and silences the speaker.
module tone_queue_player
    import tqp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int TICK_MS     = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [FREQ_W-1:0]   i_freq_in,
    input  logic [DUR_W-1:0]    i_duration_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_accepted,
    output logic                o_speaker_enable,
    output logic [DIVOUT_W-1:0] o_divisor,
    output logic [QCNT_W-1:0]   o_queued_count
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W = $clog2((65535 + TICK_MS - 1) / TICK_MS + 1);
    localparam int SUM_W  = DUR_W + 1;
    localparam int RCP_SH = SUM_W + $clog2(TICK_MS);
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam longint unsigned RCP_ONE = 64'd1 << RCP_SH;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'((RCP_ONE + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

    t_state              r_state;
    t_state              n_state;
    logic                r_active;
    logic                n_active;
    logic [TICK_W-1:0]   r_ticks;
    logic [TICK_W-1:0]   n_ticks;
    logic [DIVOUT_W-1:0] r_cur_div;
    logic [DIVOUT_W-1:0] n_cur_div;
    logic                r_accepted;
    logic                n_accepted;

    logic                req_fire;
    logic                q_push;
    logic                q_pop;
    logic [FREQ_W-1:0]   q_freq;
    logic [DUR_W-1:0]    q_dur;
    logic [CNT_W-1:0]    q_count;
    logic                q_full;

    logic                div_start;
    logic                div_done;
    logic [DVD_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DVD_W-1:0]    div_quotient;
    logic [FREQ_W-1:0]   freq_clamped;

    logic [SUM_W-1:0]    dur_sum;
    logic [PROD_W-1:0]   dur_prod;
    logic [TICK_W-1:0]   tick_quot;

    assign o_ready  = (r_state == S_IDLE);
    assign req_fire = i_valid && o_ready;
    assign q_full   = (q_count == CNT_W'(QUEUE_DEPTH));

    tqp_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_freq  (i_freq_in),
        .i_dur   (i_duration_in),
        .i_pop   (q_pop),
        .o_freq  (q_freq),
        .o_dur   (q_dur),
        .o_count (q_count)
    );

    tqp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        priority if (q_freq < FREQ_MIN) begin
            freq_clamped = FREQ_MIN;
        end else if (q_freq > FREQ_MAX) begin
            freq_clamped = FREQ_MAX;
        end else begin
            freq_clamped = q_freq;
        end
    end

    // ceil(ms / TICK_MS) by reciprocal multiply
    always_comb begin
        dur_sum   = SUM_W'(q_dur) + SUM_W'(TICK_MS - 1);
        dur_prod  = PROD_W'(dur_sum) * PROD_W'(RCP_M);
        tick_quot = dur_prod[RCP_SH +: TICK_W];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    if (i_kind == KIND_REQ) begin
                        n_state = (!q_full && !r_active) ? S_POP : S_RESP;
                    end else if (r_active && r_ticks <= TICK_W'(1)
                                 && q_count != '0) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_POP:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIVF;
            S_DIVF: begin
                if (div_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes and register updates
    always_comb begin
        q_push       = 1'b0;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = PIT_CLOCK;
        div_divisor  = DVS_W'(freq_clamped);
        n_active     = r_active;
        n_ticks      = r_ticks;
        n_cur_div    = r_cur_div;
        n_accepted   = r_accepted;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_accepted = 1'b0;
                    if (i_kind == KIND_REQ) begin
                        if (!q_full) begin
                            q_push     = 1'b1;
                            n_accepted = 1'b1;
                        end
                    end else if (r_active) begin
                        if (r_ticks != '0) begin
                            n_ticks = r_ticks - 1'b1;
                        end
                        if (r_ticks <= TICK_W'(1)) begin
                            n_active = 1'b0;
                            n_ticks  = '0;
                        end
                    end
                end
            end
            S_POP: begin
                q_pop = 1'b1;
            end
            S_LOAD: begin
                div_start = 1'b1;
            end
            S_DIVF: begin
                if (div_done) begin
                    n_active  = 1'b1;
                    n_cur_div = div_quotient[DIVOUT_W-1:0];
                    n_ticks   = (tick_quot == '0) ? TICK_W'(1) : tick_quot;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= 1'b0;
            r_ticks    <= '0;
            r_cur_div  <= '0;
            r_accepted <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_ticks    <= n_ticks;
            r_cur_div  <= n_cur_div;
            r_accepted <= n_accepted;
        end
    end

    assign o_valid          = (r_state == S_RESP);
    assign o_accepted       = r_accepted;
    assign o_speaker_enable = r_active;
    assign o_divisor        = r_active ? r_cur_div : '0;
    assign o_queued_count   = QCNT_W'(q_count);

endmodule

[tb/tone_queue_player_test.sv]
module tone_queue_player_test
    import tqp_pkg::*;
();

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int TICK_LEN_MS = 10;

    typedef struct packed {
        logic                accepted;
        logic                speaker_enable;
        logic [DIVOUT_W-1:0] divisor;
        logic [QCNT_W-1:0]   queued_count;
    } t_tone_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_kind;
    logic [FREQ_W-1:0]   i_freq_in;
    logic [DUR_W-1:0]    i_duration_in;
    logic                o_valid;
    logic                i_ready;
    logic                o_accepted;
    logic                o_speaker_enable;
    logic [DIVOUT_W-1:0] o_divisor;
    logic [QCNT_W-1:0]   o_queued_count;

    // shadow copy of the player state
    logic [FREQ_W-1:0]   pend_freq [QDEPTH];
    logic [DUR_W-1:0]    pend_dur  [QDEPTH];
    logic [QPTR_W-1:0]   pend_head;
    int                  pend_count;
    logic                sounding;
    int                  ticks_remaining;
    logic [DIVOUT_W-1:0] sound_div;

    t_tone_result        expected_tones [$];
    int                  mismatch_cnt;
    int                  hold_off_cycles;
    logic                no_idle;

    tone_queue_player #(
        .QUEUE_DEPTH (QDEPTH),
        .TICK_MS     (TICK_LEN_MS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_freq_in        (i_freq_in),
        .i_duration_in    (i_duration_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_speaker_enable (o_speaker_enable),
        .o_divisor        (o_divisor),
        .o_queued_count   (o_queued_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void start_queued_tone();
        int fq;
        int ms;
        if (pend_count == 0) begin
            sounding = 1'b0;
            ticks_remaining = 0;
            return;
        end
        fq = int'(pend_freq[pend_head]);
        ms = int'(pend_dur[pend_head]);
        pend_head = QPTR_W'((int'(pend_head) + 1) % QDEPTH);
        pend_count--;
        if (fq < int'(FREQ_MIN)) fq = int'(FREQ_MIN);
        if (fq > int'(FREQ_MAX)) fq = int'(FREQ_MAX);
        sound_div = DIVOUT_W'(int'(PIT_CLOCK) / fq);
        ticks_remaining = (ms + TICK_LEN_MS - 1) / TICK_LEN_MS;
        if (ticks_remaining < 1) ticks_remaining = 1;
        sounding = 1'b1;
    endfunction

    function automatic t_tone_result predict_tone(input logic kind,
                                                  input logic [FREQ_W-1:0] fq,
                                                  input logic [DUR_W-1:0] ms);
        t_tone_result      r;
        logic [QPTR_W-1:0] slot;
        r.accepted = 1'b0;
        if (kind == KIND_REQ) begin
            if (pend_count < QDEPTH) begin
                slot = QPTR_W'((int'(pend_head) + pend_count) % QDEPTH);
                pend_freq[slot] = fq;
                pend_dur[slot]  = ms;
                pend_count++;
                r.accepted = 1'b1;
                if (!sounding) start_queued_tone();
            end
        end else if (sounding) begin
            if (ticks_remaining > 0) ticks_remaining--;
            if (ticks_remaining == 0) begin
                sounding = 1'b0;
                start_queued_tone();
            end
        end
        r.speaker_enable = sounding;
        r.divisor        = sounding ? sound_div : '0;
        r.queued_count   = QCNT_W'(pend_count);
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic kind, input logic [FREQ_W-1:0] fq,
                                input logic [DUR_W-1:0] ms);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_kind        = kind;
        i_freq_in     = fq;
        i_duration_in = ms;
        do @(posedge i_clk); while (!o_ready);
        expected_tones.push_back(predict_tone(kind, fq, ms));
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_request(KIND_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_with_ticks();
        while (sounding) send_tick();
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_tone_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tones.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: acc=%0d spk=%0d div=%0d q=%0d",
                             o_accepted, o_speaker_enable, o_divisor, o_queued_count);
            end else begin
                want = expected_tones.pop_front();
                if (o_accepted !== want.accepted ||
                    o_speaker_enable !== want.speaker_enable ||
                    o_divisor !== want.divisor ||
                    o_queued_count !== want.queued_count) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.accepted, want.speaker_enable, want.divisor,
                                 want.queued_count, o_accepted, o_speaker_enable,
                                 o_divisor, o_queued_count);
                end
            end
        end
    end

    // receiver side
    initial begin : result_sink
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = (hold_off_cycles > 0) ? hold_off_cycles : draw_gap();
            hold_off_cycles = 0;
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic test_silent_ticks();
        send_tick();
        send_tick();
    endtask

    task automatic test_clamp_and_short();
        send_request(KIND_REQ, 16'd0, 16'd0);
        send_tick();
        send_request(KIND_REQ, 16'd19, 16'd1);
        send_tick();
        send_request(KIND_REQ, 16'd20, 16'd9);
        send_request(KIND_REQ, 16'd20000, 16'd10);
        send_request(KIND_REQ, 16'd20001, 16'd11);
        drain_with_ticks();
        send_tick();
    endtask

    task automatic test_queue_full();
        send_request(KIND_REQ, 16'd440, 16'd30);
        send_request(KIND_REQ, 16'd1000, 16'd10);
        send_request(KIND_REQ, 16'd21, 16'd20);
        send_request(KIND_REQ, 16'd19999, 16'd0);
        send_request(KIND_REQ, 16'd8000, 16'd5);
        send_request(KIND_REQ, 16'hFFFF, 16'h8000);
        send_request(KIND_REQ, 16'h5555, 16'hAAAA);
        drain_with_ticks();
    endtask

    // longest tone: must still sound after a run of ticks
    task automatic test_long_tone();
        no_idle = 1'b1;
        drain_with_ticks();
        send_request(KIND_REQ, 16'hFFFF, 16'hFFFF);
        repeat (20) send_tick();
        no_idle = 1'b0;
    endtask

    task automatic test_receiver_hold();
        hold_off_cycles = 300;
        send_request(KIND_REQ, 16'd3000, 16'd20);
        send_request(KIND_REQ, 16'd50, 16'd15);
        send_tick();
        send_request(KIND_REQ, 16'd12345, 16'd40);
        send_tick();
        send_tick();
        send_request(KIND_REQ, 16'd7, 16'd3);
        send_tick();
        drain_with_ticks();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic              is_tick;
        logic [FREQ_W-1:0] fq;
        logic [DUR_W-1:0]  ms;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (sounding && pend_count == QDEPTH)
                is_tick = ($urandom_range(0, 3) != 0);
            else
                is_tick = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 9))
                0:       fq = 16'($urandom_range(0, 19));
                1:       fq = 16'($urandom_range(20001, 65535));
                2:       fq = 16'($urandom);
                default: fq = 16'($urandom_range(20, 20000));
            endcase
            if (pend_count == QDEPTH)
                ms = 16'($urandom);
            else if ($urandom_range(0, 9) == 0)
                ms = 16'($urandom_range(0, 2047));
            else
                ms = 16'($urandom_range(0, 50));
            if (is_tick)
                send_request(KIND_TICK, fq, ms);
            else
                send_request(KIND_REQ, fq, ms);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_kind          = KIND_REQ;
        i_freq_in       = '0;
        i_duration_in   = '0;
        i_ready         = 1'b0;
        mismatch_cnt    = 0;
        hold_off_cycles = 0;
        no_idle         = 1'b0;
        pend_head       = '0;
        pend_count      = 0;
        sounding        = 1'b0;
        ticks_remaining = 0;
        sound_div       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_silent_ticks();
        test_clamp_and_short();
        test_queue_full();
        test_receiver_hold();
        test_random_traffic(860);
        test_long_tone();

        i_valid = 1'b0;
        while (expected_tones.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_tones.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
